// ----- sv/ippt_pkg.sv -----
// Shared types, codes and prefix helpers for the IPv6 prefix pool table.
package ippt_pkg;

    localparam int ENTRIES_DEF = 16;

    typedef enum logic [2:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_FLUSH   = 3'd3,
        CMD_PEEK    = 3'd4,
        CMD_REPLACE = 3'd5
    } ippt_cmd_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_INVALID  = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_EXISTS   = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_SINGLE   = 3'd5
    } ippt_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } ippt_state_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [6:0]  len;
    } ippt_entry_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  len;
        logic        exact;
    } ippt_query_t;

    typedef struct packed {
        logic        found;
        ippt_entry_t entry;
    } ippt_link_t;

    typedef struct packed {
        logic active;
        logic wr;
        logic shift_en;
    } ippt_cell_ctl_t;

    function automatic logic [63:0] mask_hi(input logic [6:0] len);
        logic [63:0] m;
        if (len == 7'd0) begin
            m = 64'd0;
        end else if (len >= 7'd64) begin
            m = {64{1'b1}};
        end else begin
            m = {64{1'b1}} << (7'd64 - len);
        end
        return m;
    endfunction

    function automatic logic [63:0] mask_lo(input logic [6:0] len);
        logic [63:0] m;
        if (len <= 7'd64) begin
            m = 64'd0;
        end else begin
            m = {64{1'b1}} << (8'd128 - {1'b0, len});
        end
        return m;
    endfunction

    function automatic logic prefix_valid(input logic [63:0] hi, input logic [63:0] lo,
                                          input logic [7:0] len);
        logic len_ok;
        len_ok = (len == 8'd32) || (len == 8'd40) || (len == 8'd48) ||
                 (len == 8'd56) || (len == 8'd64) || (len == 8'd96);
        return len_ok && ((hi & ~mask_hi(len[6:0])) == 64'd0) &&
               ((lo & ~mask_lo(len[6:0])) == 64'd0);
    endfunction

endpackage

// ----- sv/ippt_if.sv -----
// Request and response channel interfaces of the IPv6 prefix pool table.
interface ippt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;

    modport source (output valid, output cmd, output addr_hi, output addr_lo,
                    output prefix_len, input ready);
    modport sink (input valid, input cmd, input addr_hi, input addr_lo,
                  input prefix_len, output ready);
endinterface

interface ippt_rsp_if #(
    parameter int CNT_W = 5
);
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [63:0]      match_hi;
    logic [63:0]      match_lo;
    logic [6:0]       match_len;
    logic [CNT_W-1:0] entry_total;

    modport source (output valid, output status, output match_hi, output match_lo,
                    output match_len, output entry_total, input ready);
    modport sink (input valid, input status, input match_hi, input match_lo,
                  input match_len, input entry_total, output ready);
endinterface

// ----- sv/ipv6_prefix_pool_table.sv -----
// Top level of the IPv6 prefix pool table: control, fill count and cell chain.
//
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------
//  req      | in  | cmd, addr_hi, addr_lo, prefix_len
//  rsp      | out | status, match_hi, match_lo, match_len, entry_total
//  cfg      | in  | cfg_we, cfg_wdata (siit_mode)
//
//  Every command goes from accept through the scan, in which the search
//  flag walks the cell chain one cell per cycle, to the commit step.
//  The next request is taken as soon as the result sits in the output
//  register; a stalled response holds the commit step until it drains.
//  Reset clears the fill count and control; stored prefixes are not cleared.
module ipv6_prefix_pool_table #(
    parameter int ENTRIES = ippt_pkg::ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    ippt_req_if.sink      req,
    ippt_rsp_if.source    rsp
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    ippt_pkg::ippt_state_t   state_reg;
    ippt_pkg::ippt_state_t   state_next;
    logic [IDX_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic                    siit_reg;
    ippt_pkg::ippt_cmd_t     cmd_reg;
    ippt_pkg::ippt_query_t   query_reg;

    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic [2:0]              status_reg;
    logic [63:0]             match_hi_reg;
    logic [63:0]             match_lo_reg;
    logic [6:0]              match_len_reg;
    logic [CNT_W-1:0]        total_reg;

    logic                    accept;
    logic                    commit;
    ippt_pkg::ippt_status_t  status_c;
    ippt_pkg::ippt_entry_t   match_c;
    logic [CNT_W-1:0]        fill_c;
    logic                    do_add;
    logic                    do_shift;
    logic                    do_repl;
    logic                    pfx_ok;

    ippt_pkg::ippt_link_t    link [ENTRIES+1];
    ippt_pkg::ippt_entry_t   cell_entry [ENTRIES];

    assign accept = req.valid && req.ready;
    assign commit = (state_reg == ippt_pkg::S_FINISH) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ippt_pkg::S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = ippt_pkg::S_SCAN;
                end
            end
            ippt_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ippt_pkg::S_FINISH;
                end
            end
            ippt_pkg::S_FINISH:
            begin
                if (commit)
                begin
                    state_next = ippt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ippt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == ippt_pkg::S_IDLE);
        pfx_ok    = ippt_pkg::prefix_valid(query_reg.hi, query_reg.lo, query_reg.len);
        status_c  = ippt_pkg::STAT_OK;
        match_c   = '0;
        fill_c    = fill_reg;
        do_add    = 1'b0;
        do_shift  = 1'b0;
        do_repl   = 1'b0;
        case (cmd_reg)
            ippt_pkg::CMD_LOOKUP:
            begin
                if (link[ENTRIES].found)
                begin
                    match_c = link[ENTRIES].entry;
                end else
                begin
                    status_c = ippt_pkg::STAT_NOTFOUND;
                end
            end
            ippt_pkg::CMD_ADD:
            begin
                if (!pfx_ok)
                begin
                    status_c = ippt_pkg::STAT_INVALID;
                end else if (siit_reg && (fill_reg != '0))
                begin
                    status_c = ippt_pkg::STAT_SINGLE;
                end else if (link[ENTRIES].found)
                begin
                    status_c = ippt_pkg::STAT_EXISTS;
                end else if (fill_reg >= CNT_W'(ENTRIES))
                begin
                    status_c = ippt_pkg::STAT_FULL;
                end else
                begin
                    do_add = 1'b1;
                    fill_c = fill_reg + CNT_W'(1);
                end
            end
            ippt_pkg::CMD_REMOVE:
            begin
                if (link[ENTRIES].found)
                begin
                    do_shift = 1'b1;
                    fill_c   = fill_reg - CNT_W'(1);
                end else
                begin
                    status_c = ippt_pkg::STAT_NOTFOUND;
                end
            end
            ippt_pkg::CMD_FLUSH:
            begin
                fill_c = '0;
            end
            ippt_pkg::CMD_PEEK:
            begin
                if (fill_reg == '0)
                begin
                    status_c = ippt_pkg::STAT_NOTFOUND;
                end else
                begin
                    match_c = cell_entry[0];
                end
            end
            ippt_pkg::CMD_REPLACE:
            begin
                if (pfx_ok)
                begin
                    do_repl = 1'b1;
                    fill_c  = CNT_W'(1);
                end else
                begin
                    status_c = ippt_pkg::STAT_INVALID;
                end
            end
            default:
            begin
                status_c = ippt_pkg::STAT_INVALID;
            end
        endcase
        fill_next      = commit ? fill_c : fill_reg;
        rsp_valid_next = commit || (rsp_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ippt_pkg::S_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            siit_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                siit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg         <= ippt_pkg::ippt_cmd_t'(req.cmd);
            query_reg.hi    <= req.addr_hi;
            query_reg.lo    <= req.addr_lo;
            query_reg.len   <= req.prefix_len;
            query_reg.exact <= (req.cmd != ippt_pkg::CMD_LOOKUP);
        end
        if (commit)
        begin
            status_reg    <= status_c;
            match_hi_reg  <= match_c.hi;
            match_lo_reg  <= match_c.lo;
            match_len_reg <= match_c.len;
            total_reg     <= fill_c;
        end
    end

    assign link[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ippt_pkg::ippt_cell_ctl_t ctl;
        ippt_pkg::ippt_entry_t    nb;

        assign ctl.active   = (fill_reg > CNT_W'(i));
        assign ctl.wr       = commit && ((do_add && (fill_reg == CNT_W'(i))) ||
                                         (do_repl && (i == 0)));
        assign ctl.shift_en = commit && do_shift;

        if (i < ENTRIES - 1)
        begin : g_nb
            assign nb = cell_entry[i+1];
        end else
        begin : g_last
            assign nb = '0;
        end

        ippt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .query     (query_reg),
            .ctl       (ctl),
            .link_in   (link[i]),
            .nb_entry  (nb),
            .link_out  (link[i+1]),
            .entry_out (cell_entry[i])
        );
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.match_hi    = match_hi_reg;
    assign rsp.match_lo    = match_lo_reg;
    assign rsp.match_len   = match_len_reg;
    assign rsp.entry_total = total_reg;

endmodule

// ----- sv/ippt_cell.sv -----
// One table slot: stored prefix, match logic and one stage of the search chain.
module ippt_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ippt_pkg::ippt_query_t   query,
    input  ippt_pkg::ippt_cell_ctl_t ctl,
    input  ippt_pkg::ippt_link_t    link_in,
    input  ippt_pkg::ippt_entry_t   nb_entry,
    output ippt_pkg::ippt_link_t    link_out,
    output ippt_pkg::ippt_entry_t   entry_out
);

    ippt_pkg::ippt_entry_t entry_reg;
    ippt_pkg::ippt_entry_t entry_next;
    ippt_pkg::ippt_link_t  link_reg;
    ippt_pkg::ippt_link_t  link_next;
    logic                  exact_hit;
    logic                  cover_hit;
    logic                  hit;

    always_comb
    begin
        exact_hit = (entry_reg.hi == query.hi) && (entry_reg.lo == query.lo) &&
                    ({1'b0, entry_reg.len} == query.len);
        cover_hit = (((entry_reg.hi ^ query.hi) & ippt_pkg::mask_hi(entry_reg.len)) == 64'd0) &&
                    (((entry_reg.lo ^ query.lo) & ippt_pkg::mask_lo(entry_reg.len)) == 64'd0);
        hit       = ctl.active && (query.exact ? exact_hit : cover_hit);
    end

    // pass the earlier hit along, or claim the beat
    always_comb
    begin
        link_next.found = link_in.found || hit;
        link_next.entry = link_in.found ? link_in.entry : entry_reg;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.wr)
        begin
            entry_next.hi  = query.hi;
            entry_next.lo  = query.lo;
            entry_next.len = query.len[6:0];
        end else if (ctl.shift_en && link_reg.found)
        begin
            entry_next = nb_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end else
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link_out  = link_reg;
    assign entry_out = entry_reg;

endmodule
